>>> src/mrm_pkg.sv
// shared types and constants for the modular matrix rank block
`timescale 1ns / 1ps

package mrm_pkg;

  localparam int WORD_W = 32;
  localparam int DIM_W  = 7;

  localparam logic [WORD_W-1:0] MODULUS_RESET   = 32'd1000000007;
  localparam logic [DIM_W-1:0]  DIMENSION_RESET = 7'd64;

  // configuration register indexes
  localparam logic [0:0] REG_MODULUS   = 1'b0;
  localparam logic [0:0] REG_DIMENSION = 1'b1;

  // request to the modular multiplier
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mm_req_t;

  // response of the modular multiplier
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] result;
  } mm_rsp_t;

endpackage

>>> src/mrm_modmul.sv
// bit-serial modular multiplier: (a * b) mod p, one remainder bit per cycle
`timescale 1ns / 1ps

module mrm_modmul (
  input  logic                         clk,
  input  logic                         rst,
  input  mrm_pkg::mm_req_t             req,
  input  logic [mrm_pkg::WORD_W-1:0]   modulus,
  output mrm_pkg::mm_rsp_t             rsp
);

  logic        busy;
  logic        mul_pend;
  logic        done;
  logic [5:0]  cnt;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [31:0] p_r;
  logic [63:0] prod;
  logic [32:0] rem;
  logic [32:0] shifted;
  logic [32:0] rem_next;

  always_comb begin
    shifted  = {rem[31:0], prod[63]};
    rem_next = (shifted >= {1'b0, p_r}) ? shifted - {1'b0, p_r} : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      mul_pend <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        a_r      <= req.a;
        b_r      <= req.b;
        p_r      <= modulus;
        busy     <= 1'b1;
        mul_pend <= 1'b1;
      end else if (mul_pend) begin
        prod     <= 64'(a_r) * 64'(b_r);
        rem      <= '0;
        cnt      <= '0;
        mul_pend <= 1'b0;
      end else if (busy) begin
        prod <= {prod[62:0], 1'b0};
        rem  <= rem_next;
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{busy: busy, done: done, result: rem[31:0]};

endmodule

>>> src/matrix_rank_mod_prime.sv
// top level: rank of a square matrix over the integers modulo a prime
`timescale 1ns / 1ps

// Loads an n x n matrix one entry per input beat in row-major order and,
// on the beat marked last_entry, computes its rank modulo the configured
// prime by Gauss-Jordan elimination, then gives one output beat holding
// the rank. Each entry is reduced modulo the prime as it is stored; the
// load position wraps after n*n entries and returns to 0 after a last
// entry, so a short matrix reuses entries from earlier loads. Two
// memories of MAX_DIM*MAX_DIM words, each with one read and one write
// port, hold the state: the
// matrix store, written only by loads, and a working copy that the
// elimination reads, modifies and writes back one word at a time. All
// modular multiplication goes through one shared bit-serial multiplier
// that forms the 64-bit product in a multiply step and then reduces it
// one remainder bit per cycle. A load beat therefore holds off the input
// until its product is done. After the last entry the elimination copies and
// reduces all n*n entries, then for each pivot runs a square-and-multiply
// inverse (up to 64 products) and about n*n further products; input stalls
// until the rank is handed over. A modulus below 2 or a dimension of 0
// gives rank 0 at once. Configuration writes are taken at any time but
// must only be made while the block is idle.

module matrix_rank_mod_prime #(
  parameter int MAX_DIM = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] matrix_entry,
  input  logic        last_entry,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  rank
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_DIM + 1);

  // one-hot sequencer states
  typedef enum logic [28:0] {
    S_IDLE    = 29'h0000001,
    S_LD_WAIT = 29'h0000002,
    S_CP_RD   = 29'h0000004,
    S_CP_MM   = 29'h0000008,
    S_CP_WAIT = 29'h0000010,
    S_COL     = 29'h0000020,
    S_SR_RD   = 29'h0000040,
    S_SR_CHK  = 29'h0000080,
    S_SW_RDA  = 29'h0000100,
    S_SW_RDB  = 29'h0000200,
    S_SW_WRA  = 29'h0000400,
    S_SW_WRB  = 29'h0000800,
    S_PV_RD   = 29'h0001000,
    S_PV_INIT = 29'h0002000,
    S_PW_TOP  = 29'h0004000,
    S_PW_ACC  = 29'h0008000,
    S_PW_SQS  = 29'h0010000,
    S_PW_SQ   = 29'h0020000,
    S_NM_RD   = 29'h0040000,
    S_NM_MM   = 29'h0080000,
    S_NM_WAIT = 29'h0100000,
    S_EL_ROW  = 29'h0200000,
    S_EL_F    = 29'h0400000,
    S_EL_RD1  = 29'h0800000,
    S_EL_MM   = 29'h1000000,
    S_EL_WAIT = 29'h2000000,
    S_EL_RD2  = 29'h4000000,
    S_EL_WR   = 29'h8000000,
    S_DONE    = 29'h10000000
  } state_t;

  state_t state;

  // configuration
  logic [31:0] modulus;
  logic [6:0]  dimension;

  // load side
  logic [AW-1:0] load_pos;
  logic [AW-1:0] ld_addr;
  logic          ld_last;

  // elimination counters and operands
  logic [AW-1:0] k;
  logic [CW-1:0] r;
  logic [CW-1:0] c;
  logic [CW-1:0] q;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [31:0]   ta;
  logic [31:0]   base;
  logic [31:0]   acc;
  logic [31:0]   e;
  logic [31:0]   inv;
  logic [31:0]   f;
  logic [31:0]   sub;
  logic [6:0]    res_rank;

  // derived config
  logic [CW-1:0] n_eff;
  logic [AW:0]   nn;
  logic          mod_ok;
  logic          accept;
  logic [AW-1:0] pos_eff;

  // memories
  logic [31:0]   store_mem [DEPTH];
  logic [31:0]   work_mem  [DEPTH];
  logic          store_we;
  logic [AW-1:0] store_waddr;
  logic [31:0]   store_wdata;
  logic [31:0]   store_rdata;
  logic          work_we;
  logic [AW-1:0] work_waddr;
  logic [31:0]   work_wdata;
  logic [AW-1:0] work_raddr;
  logic [31:0]   work_rdata;
  logic [CW-1:0] rd_row;
  logic [CW-1:0] rd_col;
  logic [CW-1:0] wr_row;
  logic [CW-1:0] wr_col;
  logic [31:0]   diff;

  mrm_pkg::mm_req_t mm_req;
  mrm_pkg::mm_rsp_t mm_rsp;

  function automatic logic [AW-1:0] idx(input logic [CW-1:0] row,
                                        input logic [CW-1:0] col,
                                        input logic [CW-1:0] n);
    logic [2*CW-1:0] lin;
    lin = (2*CW)'(row) * (2*CW)'(n) + (2*CW)'(col);
    return lin[AW-1:0];
  endfunction

  function automatic logic at_end(input logic [CW-1:0] x, input logic [CW-1:0] n);
    return ({1'b0, x} + 1'b1) == {1'b0, n};
  endfunction

  function automatic logic [AW-1:0] pos_wrap(input logic [AW-1:0] x, input logic [AW:0] lim);
    logic [AW:0] nx;
    nx = {1'b0, x} + 1'b1;
    return (nx >= lim) ? '0 : nx[AW-1:0];
  endfunction

  // dimension saturates at MAX_DIM
  assign n_eff   = ({25'd0, dimension} > 32'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(dimension);
  assign nn      = (AW+1)'({{CW{1'b0}}, n_eff} * {{CW{1'b0}}, n_eff});
  assign mod_ok  = (modulus >= 32'd2);
  assign in_stall = (state != S_IDLE);
  assign accept  = in_valid && !in_stall;
  assign pos_eff = ({1'b0, load_pos} >= nn) ? '0 : load_pos;

  mrm_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .req     (mm_req),
    .modulus (modulus),
    .rsp     (mm_rsp)
  );

  // multiplier requests
  always_comb begin
    mm_req = '{start: 1'b0, a: base, b: base};
    case (state)
      S_IDLE: begin
        mm_req = '{start: accept && (nn != '0) && mod_ok, a: matrix_entry, b: 32'd1};
      end
      S_CP_MM: begin
        mm_req = '{start: 1'b1, a: store_rdata, b: 32'd1};
      end
      S_PW_TOP: begin
        if (e[0]) begin
          mm_req = '{start: 1'b1, a: acc, b: base};
        end else begin
          mm_req = '{start: e != 32'd0, a: base, b: base};
        end
      end
      S_PW_SQS: begin
        mm_req = '{start: 1'b1, a: base, b: base};
      end
      S_NM_MM: begin
        mm_req = '{start: 1'b1, a: work_rdata, b: inv};
      end
      S_EL_MM: begin
        mm_req = '{start: 1'b1, a: f, b: work_rdata};
      end
      default: begin
        mm_req = '{start: 1'b0, a: base, b: base};
      end
    endcase
  end

  // store write: load results, or zero under a degenerate modulus
  always_comb begin
    store_we    = 1'b0;
    store_waddr = ld_addr;
    store_wdata = mm_rsp.result;
    if (state == S_IDLE) begin
      store_we    = accept && (nn != '0) && !mod_ok;
      store_waddr = pos_eff;
      store_wdata = 32'd0;
    end else if (state == S_LD_WAIT) begin
      store_we = mm_rsp.done;
    end
  end

  // working copy read address
  always_comb begin
    rd_row = r;
    rd_col = j;
    case (state)
      S_SR_RD:  begin rd_row = q; rd_col = c; end
      S_SW_RDA: begin rd_row = q; rd_col = j; end
      S_PV_RD:  begin rd_row = r; rd_col = c; end
      S_EL_ROW: begin rd_row = i; rd_col = c; end
      S_EL_RD2: begin rd_row = i; rd_col = j; end
      default:  begin rd_row = r; rd_col = j; end
    endcase
    work_raddr = idx(rd_row, rd_col, n_eff);
  end

  // modular subtraction of the scaled pivot row
  assign diff = (work_rdata >= sub) ? work_rdata - sub
              : 32'({1'b0, work_rdata} + {1'b0, modulus} - {1'b0, sub});

  // working copy write
  always_comb begin
    work_we    = 1'b0;
    work_wdata = mm_rsp.result;
    wr_row     = r;
    wr_col     = j;
    case (state)
      S_CP_WAIT: work_we = mm_rsp.done;
      S_SW_WRA: begin
        work_we    = 1'b1;
        work_wdata = work_rdata;
        wr_row     = q;
      end
      S_SW_WRB: begin
        work_we    = 1'b1;
        work_wdata = ta;
      end
      S_NM_WAIT: work_we = mm_rsp.done;
      S_EL_WR: begin
        work_we    = 1'b1;
        work_wdata = diff;
        wr_row     = i;
      end
      default: work_we = 1'b0;
    endcase
    work_waddr = (state == S_CP_WAIT) ? k : idx(wr_row, wr_col, n_eff);
  end

  // memories
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    store_rdata <= store_mem[k];
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    work_rdata <= work_mem[work_raddr];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= mrm_pkg::MODULUS_RESET;
      dimension <= mrm_pkg::DIMENSION_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mrm_pkg::REG_MODULUS:   modulus   <= cfg_data;
        mrm_pkg::REG_DIMENSION: dimension <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      load_pos  <= '0;
      out_valid <= 1'b0;
      r         <= '0;
      c         <= '0;
    end else begin
      // the hand-over state drives out_valid itself
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (nn == '0) begin
              load_pos <= '0;
              if (last_entry) begin
                res_rank <= 7'd0;
                state    <= S_DONE;
              end
            end else if (!mod_ok) begin
              // every entry counts as zero
              load_pos <= last_entry ? '0 : pos_wrap(pos_eff, nn);
              if (last_entry) begin
                res_rank <= 7'd0;
                state    <= S_DONE;
              end
            end else begin
              ld_addr <= pos_eff;
              ld_last <= last_entry;
              state   <= S_LD_WAIT;
            end
          end
        end
        S_LD_WAIT: begin
          if (mm_rsp.done) begin
            if (ld_last) begin
              load_pos <= '0;
              k        <= '0;
              state    <= S_CP_RD;
            end else begin
              load_pos <= pos_wrap(ld_addr, nn);
              state    <= S_IDLE;
            end
          end
        end
        // copy and reduce the store into the working matrix
        S_CP_RD: state <= S_CP_MM;
        S_CP_MM: state <= S_CP_WAIT;
        S_CP_WAIT: begin
          if (mm_rsp.done) begin
            if (({1'b0, k} + 1'b1) == nn) begin
              r     <= '0;
              c     <= '0;
              state <= S_COL;
            end else begin
              k     <= k + 1'b1;
              state <= S_CP_RD;
            end
          end
        end
        S_COL: begin
          if (c == n_eff || r == n_eff) begin
            res_rank <= 7'(r);
            state    <= S_DONE;
          end else begin
            q     <= r;
            state <= S_SR_RD;
          end
        end
        // pivot search down the column
        S_SR_RD: state <= S_SR_CHK;
        S_SR_CHK: begin
          if (work_rdata == 32'd0) begin
            if (at_end(q, n_eff)) begin
              c     <= c + 1'b1;
              state <= S_COL;
            end else begin
              q     <= q + 1'b1;
              state <= S_SR_RD;
            end
          end else if (q != r) begin
            j     <= c;
            state <= S_SW_RDA;
          end else begin
            state <= S_PV_RD;
          end
        end
        // row swap from the pivot column on
        S_SW_RDA: state <= S_SW_RDB;
        S_SW_RDB: begin
          ta    <= work_rdata;
          state <= S_SW_WRA;
        end
        S_SW_WRA: state <= S_SW_WRB;
        S_SW_WRB: begin
          if (at_end(j, n_eff)) begin
            state <= S_PV_RD;
          end else begin
            j     <= j + 1'b1;
            state <= S_SW_RDA;
          end
        end
        // fermat inverse of the pivot
        S_PV_RD: state <= S_PV_INIT;
        S_PV_INIT: begin
          base  <= work_rdata;
          acc   <= 32'd1;
          e     <= modulus - 32'd2;
          state <= S_PW_TOP;
        end
        S_PW_TOP: begin
          if (e == 32'd0) begin
            inv   <= acc;
            j     <= c;
            state <= S_NM_RD;
          end else if (e[0]) begin
            state <= S_PW_ACC;
          end else begin
            state <= S_PW_SQ;
          end
        end
        S_PW_ACC: begin
          if (mm_rsp.done) begin
            acc   <= mm_rsp.result;
            state <= S_PW_SQS;
          end
        end
        S_PW_SQS: state <= S_PW_SQ;
        S_PW_SQ: begin
          if (mm_rsp.done) begin
            base  <= mm_rsp.result;
            e     <= {1'b0, e[31:1]};
            state <= S_PW_TOP;
          end
        end
        // normalize the pivot row
        S_NM_RD: state <= S_NM_MM;
        S_NM_MM: state <= S_NM_WAIT;
        S_NM_WAIT: begin
          if (mm_rsp.done) begin
            if (at_end(j, n_eff)) begin
              i     <= '0;
              state <= S_EL_ROW;
            end else begin
              j     <= j + 1'b1;
              state <= S_NM_RD;
            end
          end
        end
        // clear the column from every other row
        S_EL_ROW: begin
          if (i == n_eff) begin
            r     <= r + 1'b1;
            c     <= c + 1'b1;
            state <= S_COL;
          end else if (i == r) begin
            i <= i + 1'b1;
          end else begin
            state <= S_EL_F;
          end
        end
        S_EL_F: begin
          f <= work_rdata;
          if (work_rdata == 32'd0) begin
            i     <= i + 1'b1;
            state <= S_EL_ROW;
          end else begin
            j     <= c;
            state <= S_EL_RD1;
          end
        end
        S_EL_RD1: state <= S_EL_MM;
        S_EL_MM:  state <= S_EL_WAIT;
        S_EL_WAIT: begin
          if (mm_rsp.done) begin
            sub   <= mm_rsp.result;
            state <= S_EL_RD2;
          end
        end
        S_EL_RD2: state <= S_EL_WR;
        S_EL_WR: begin
          if (at_end(j, n_eff)) begin
            i     <= i + 1'b1;
            state <= S_EL_ROW;
          end else begin
            j     <= j + 1'b1;
            state <= S_EL_RD1;
          end
        end
        // hand over the rank once the output register is free
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            rank      <= res_rank;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the shared multiplier is only started when it is free
  a_mm_free: assert property (@(posedge clk) disable iff (rst)
    mm_req.start |-> !mm_rsp.busy)
    else $error("multiplier started while busy");

  // pivots never outnumber the columns visited
  a_rank_le_col: assert property (@(posedge clk) disable iff (rst)
    r <= c)
    else $error("rank counter ahead of column counter");

  // a last entry always starts work that holds off the input
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_entry |=> in_stall)
    else $error("input not held after last entry");

  // a result appears only from the hand-over state
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside hand-over");

endmodule
